// ===== hw/rtl/mqtt_control_packet_parser_core_defines.svh =====
// Assertion helpers for the MQTT parser.
`ifndef MQTT_CONTROL_PACKET_PARSER_CORE_DEFINES_SVH
`define MQTT_CONTROL_PACKET_PARSER_CORE_DEFINES_SVH

// same-cycle implication
`define MCPP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mcpp assertion failed");

// next-cycle implication
`define MCPP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mcpp assertion failed");

`endif

// ===== hw/rtl/mcpp_pkg.sv =====
package mcpp_pkg;

	localparam logic [3:0] K_REMLEN    = 4'd0;
	localparam logic [3:0] K_STRLEN    = 4'd1;
	localparam logic [3:0] K_STRBYTE   = 4'd2;
	localparam logic [3:0] K_LEVEL     = 4'd3;
	localparam logic [3:0] K_CFLAGS    = 4'd4;
	localparam logic [3:0] K_KEEPALIVE = 4'd5;
	localparam logic [3:0] K_ID        = 4'd6;
	localparam logic [3:0] K_QOS       = 4'd7;
	localparam logic [3:0] K_PAYLOAD   = 4'd8;
	localparam logic [3:0] K_ERROR     = 4'd9;

	localparam logic [2:0] E_NONE     = 3'd0;
	localparam logic [2:0] E_OVERRUN  = 3'd1;
	localparam logic [2:0] E_FLAGS    = 3'd2;
	localparam logic [2:0] E_NOT_MQTT = 3'd3;
	localparam logic [2:0] E_LEVEL    = 3'd4;
	localparam logic [2:0] E_CLIENTID = 3'd5;
	localparam logic [2:0] E_RESERVED = 3'd6;
	localparam logic [2:0] E_UNKNOWN  = 3'd7;

	localparam logic [2:0] R_PROTONAME = 3'd0;
	localparam logic [2:0] R_CLIENTID  = 3'd1;
	localparam logic [2:0] R_WILLTOPIC = 3'd2;
	localparam logic [2:0] R_WILLMSG   = 3'd3;
	localparam logic [2:0] R_USER      = 3'd4;
	localparam logic [2:0] R_PASSWORD  = 3'd5;
	localparam logic [2:0] R_TOPIC     = 3'd6;
	localparam logic [2:0] R_FILTER    = 3'd7;

	localparam logic [3:0] T_CONNECT     = 4'd1;
	localparam logic [3:0] T_PUBLISH     = 4'd3;
	localparam logic [3:0] T_PUBACK      = 4'd4;
	localparam logic [3:0] T_PUBREC      = 4'd5;
	localparam logic [3:0] T_PUBREL      = 4'd6;
	localparam logic [3:0] T_PUBCOMP     = 4'd7;
	localparam logic [3:0] T_SUBSCRIBE   = 4'd8;
	localparam logic [3:0] T_UNSUBSCRIBE = 4'd10;
	localparam logic [3:0] T_PINGREQ     = 4'd12;
	localparam logic [3:0] T_DISCONNECT  = 4'd14;

	localparam logic [1:0] CFG_LEVEL    = 2'd0;
	localparam logic [1:0] CFG_CID_LIM  = 2'd1;

	localparam logic [7:0] LEVEL_RESET  = 8'h04;
	localparam logic [15:0] CID_RESET   = 16'd63;

	typedef struct packed {
		logic [3:0]  packet_type;
		logic [3:0]  header_flags;
		logic [3:0]  field_kind;
		logic [2:0]  string_role;
		logic [27:0] field_value;
		logic [2:0]  fault_code;
		logic        end_of_packet;
	} result_t;

	function automatic logic [7:0] name_char(input logic [1:0] pos);
		case (pos)
			2'd0: name_char = 8'h4D;
			2'd1: name_char = 8'h51;
			2'd2: name_char = 8'h54;
			default: name_char = 8'h54;
		endcase
	endfunction

endpackage

// ===== hw/rtl/mqtt_control_packet_parser_core.sv =====
// MQTT 3.1.1 control packet parser.
// Input channel: one stream byte per beat on data_byte (in_valid/in_ready).
// Output channel: one decoded field per beat (out_valid/out_ready): packet type,
//   header flags, field kind, string role, value, fault code, end-of-packet.
// Config channel: cfg_valid/cfg_ready with cfg_index (0 protocol level,
//   1 client id limit) and cfg_data; always ready, write only while idle.
// Output path: a byte that yields a field is written into the result queue and
//   reaches the output from its head. Header, continued length bytes, high bytes
//   of 16-bit fields and skipped bytes yield nothing.
// Throughput: one byte per cycle while the queue is not full; the byte parser
//   decodes each byte combinationally and hands results through a two-entry queue to the output.
// Stall: when the receiver holds out_ready low the queue fills, and in_ready
//   drops only once both entries are taken.
// Reset (arst_n low): parser awaits a header byte, queue empties, protocol
//   level returns to 4 and client id limit to 63.
// On a protocol error one error beat with end_of_packet is given and the rest
//   of the packet is skipped; an over-long length field returns to the header.
`include "mqtt_control_packet_parser_core_defines.svh"

module mqtt_control_packet_parser_core #(
	parameter int MAX_LENGTH_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  packet_type,
	output logic [3:0]  header_flags,
	output logic [3:0]  field_kind,
	output logic [2:0]  string_role,
	output logic [27:0] field_value,
	output logic [2:0]  fault_code,
	output logic        end_of_packet,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [7:0]  level_q;
	logic [15:0] cid_limit_q;
	logic        take, res_valid, full, pop;
	logic        err_beat, data_beat, lvl_wr;
	mcpp_pkg::result_t res, head;

	assign cfg_ready = 1'b1;
	assign in_ready = !full;
	assign take = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= mcpp_pkg::LEVEL_RESET;
			cid_limit_q <= mcpp_pkg::CID_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == mcpp_pkg::CFG_LEVEL) level_q <= cfg_data[7:0];
			else if (cfg_index == mcpp_pkg::CFG_CID_LIM) cid_limit_q <= cfg_data;
		end
	end

	// front: byte classifier and packet walker
	mcpp_front #(.MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)) u_front (
		.clk(clk), .arst_n(arst_n), .take(take), .data_byte(data_byte),
		.level(level_q), .cid_limit(cid_limit_q),
		.res_valid(res_valid), .res(res)
	);

	// back: result queue feeding the output port
	mcpp_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(res_valid), .push_data(res),
		.pop(pop), .full(full), .not_empty(out_valid), .head(head)
	);

	assign packet_type = head.packet_type;
	assign header_flags = head.header_flags;
	assign field_kind = head.field_kind;
	assign string_role = head.string_role;
	assign field_value = head.field_value;
	assign fault_code = head.fault_code;
	assign end_of_packet = head.end_of_packet;

	assign err_beat = out_valid && field_kind == mcpp_pkg::K_ERROR;
	assign data_beat = out_valid && field_kind != mcpp_pkg::K_ERROR;
	assign lvl_wr = cfg_valid && cfg_index == mcpp_pkg::CFG_LEVEL;

	`MCPP_ASSERT_IMPL(a_err_eop, clk, arst_n, err_beat, end_of_packet && field_value == '0)
	`MCPP_ASSERT_IMPL(a_code_kind, clk, arst_n, data_beat, fault_code == mcpp_pkg::E_NONE)
	`MCPP_ASSERT_IMPL(a_no_push_full, clk, arst_n, res_valid, !full)
	`MCPP_ASSERT_NEXT(a_cfg_level, clk, arst_n, lvl_wr, level_q == $past(cfg_data[7:0]))

endmodule

// ===== hw/rtl/mcpp_front.sv =====
module mcpp_front #(
	parameter int MAX_LENGTH_BYTES = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          data_byte,
	input  logic [7:0]          level,
	input  logic [15:0]         cid_limit,
	output logic                res_valid,
	output mcpp_pkg::result_t   res
);

	typedef enum logic [3:0] {
		PH_HDR, PH_LEN, PH_SKIP, PH_SLEN_HI, PH_SLEN_LO, PH_SBYTE, PH_LEVEL,
		PH_CFLAGS, PH_KA_HI, PH_KA_LO, PH_ID_HI, PH_ID_LO, PH_QOS, PH_PAYLOAD,
		PH_DONE, PH_FILT_NEXT
	} ph_t;

	typedef struct packed {
		ph_t        ph;
		logic [2:0] role;
	} step_t;

	ph_t         ph_q, ph_d;
	logic [27:0] bl_q, bl_d;
	logic [1:0]  lbi_q, lbi_d;
	logic [15:0] sl_q, sl_d;
	logic [2:0]  role_q, role_d;
	logic [3:0]  type_q, type_d;
	logic [3:0]  flags_q, flags_d;
	logic [7:0]  cf_q, cf_d;
	logic [7:0]  hold_q, hold_d;
	logic [2:0]  nmp_q, nmp_d;

	function automatic step_t after_will(input logic [7:0] cf, input logic [2:0] role);
		if (cf[7]) after_will = '{PH_SLEN_HI, mcpp_pkg::R_USER};
		else if (cf[6]) after_will = '{PH_SLEN_HI, mcpp_pkg::R_PASSWORD};
		else after_will = '{PH_DONE, role};
	endfunction

	function automatic step_t after_string(input logic [2:0] role, input logic [7:0] cf,
			input logic [3:0] flags, input logic [3:0] typ);
		case (role)
			mcpp_pkg::R_PROTONAME: after_string = '{PH_LEVEL, role};
			mcpp_pkg::R_CLIENTID:
				after_string = cf[2] ? '{PH_SLEN_HI, mcpp_pkg::R_WILLTOPIC}
					: after_will(cf, role);
			mcpp_pkg::R_WILLTOPIC: after_string = '{PH_SLEN_HI, mcpp_pkg::R_WILLMSG};
			mcpp_pkg::R_WILLMSG: after_string = after_will(cf, role);
			mcpp_pkg::R_USER:
				after_string = cf[6] ? '{PH_SLEN_HI, mcpp_pkg::R_PASSWORD}
					: '{PH_DONE, role};
			mcpp_pkg::R_PASSWORD: after_string = '{PH_DONE, role};
			mcpp_pkg::R_TOPIC:
				after_string = (flags[2:1] != 2'b00) ? '{PH_ID_HI, role}
					: '{PH_PAYLOAD, role};
			default:
				after_string = (typ == mcpp_pkg::T_SUBSCRIBE) ? '{PH_QOS, role}
					: '{PH_FILT_NEXT, role};
		endcase
	endfunction

	logic        fin, has, over;
	logic [3:0]  kind;
	logic [27:0] value, left, acc, grp;
	logic [2:0]  err;
	ph_t         nxt;
	logic [15:0] len;
	logic [15:0] sl_dec;
	logic        terminal;
	logic        emit_err;
	logic [3:0]  out_kind;
	logic [27:0] out_value;
	logic        out_eop;
	step_t       st;

	always_comb begin
		ph_d = ph_q; bl_d = bl_q; lbi_d = lbi_q; sl_d = sl_q; role_d = role_q;
		type_d = type_q; flags_d = flags_q; cf_d = cf_q; hold_d = hold_q; nmp_d = nmp_q;
		fin = 1'b0; has = 1'b0; kind = mcpp_pkg::K_REMLEN; value = '0;
		err = mcpp_pkg::E_NONE; nxt = ph_q; st = '{ph_q, role_q};
		left = (bl_q == '0) ? '0 : bl_q - 28'd1;
		len = {hold_q, data_byte};
		sl_dec = (sl_q == '0) ? '0 : sl_q - 16'd1;
		emit_err = 1'b0; out_kind = mcpp_pkg::K_REMLEN; out_value = '0; out_eop = 1'b0;
		res_valid = 1'b0; terminal = 1'b0;
		over = ({1'b0, lbi_q} + 3'd1) >= 3'(MAX_LENGTH_BYTES);
		case (lbi_q)
			2'd0: grp = {21'd0, data_byte[6:0]};
			2'd1: grp = {14'd0, data_byte[6:0], 7'd0};
			2'd2: grp = {7'd0, data_byte[6:0], 14'd0};
			default: grp = {data_byte[6:0], 21'd0};
		endcase
		acc = bl_q | grp;
		if (take) begin
			case (ph_q)
				PH_HDR: begin
					type_d = data_byte[7:4];
					flags_d = data_byte[3:0];
					bl_d = '0;
					lbi_d = '0;
					ph_d = PH_LEN;
				end
				PH_LEN: begin
					bl_d = acc;
					if (!data_byte[7]) begin
						nmp_d = '0;
						sl_d = '0;
						fin = 1'b1; has = 1'b1; value = acc; left = acc;
						nxt = PH_DONE;
						case (type_q)
							mcpp_pkg::T_CONNECT: begin
								nxt = PH_SLEN_HI; role_d = mcpp_pkg::R_PROTONAME;
							end
							mcpp_pkg::T_PUBLISH: begin
								nxt = PH_SLEN_HI; role_d = mcpp_pkg::R_TOPIC;
							end
							mcpp_pkg::T_PUBACK, mcpp_pkg::T_PUBREC, mcpp_pkg::T_PUBREL,
							mcpp_pkg::T_PUBCOMP, mcpp_pkg::T_SUBSCRIBE,
							mcpp_pkg::T_UNSUBSCRIBE: nxt = PH_ID_HI;
							mcpp_pkg::T_PINGREQ, mcpp_pkg::T_DISCONNECT: nxt = PH_DONE;
							default: err = mcpp_pkg::E_UNKNOWN;
						endcase
						if (err == mcpp_pkg::E_NONE) begin
							if (type_q == mcpp_pkg::T_PUBLISH) begin
								if (flags_q[2:1] == 2'b11) err = mcpp_pkg::E_FLAGS;
							end else if (type_q == mcpp_pkg::T_PUBREL
									|| type_q == mcpp_pkg::T_SUBSCRIBE
									|| type_q == mcpp_pkg::T_UNSUBSCRIBE) begin
								if (flags_q != 4'b0010) err = mcpp_pkg::E_FLAGS;
							end else if (flags_q != 4'b0000) begin
								err = mcpp_pkg::E_FLAGS;
							end
						end
					end else if (over) begin
						bl_d = '0; lbi_d = '0; ph_d = PH_HDR;
						emit_err = 1'b1; err = mcpp_pkg::E_OVERRUN;
					end else begin
						lbi_d = lbi_q + 2'd1;
					end
				end
				PH_SKIP: begin
					bl_d = left;
					if (left == '0) ph_d = PH_HDR;
				end
				default: begin
					fin = 1'b1;
					case (ph_q)
						PH_FILT_NEXT: begin
							role_d = mcpp_pkg::R_FILTER; hold_d = data_byte; nxt = PH_SLEN_LO;
						end
						PH_SLEN_HI: begin hold_d = data_byte; nxt = PH_SLEN_LO; end
						PH_KA_HI: begin hold_d = data_byte; nxt = PH_KA_LO; end
						PH_ID_HI: begin hold_d = data_byte; nxt = PH_ID_LO; end
						PH_SLEN_LO: begin
							has = 1'b1; kind = mcpp_pkg::K_STRLEN; value = {12'd0, len};
							if (role_q == mcpp_pkg::R_PROTONAME && len != 16'd4)
								err = mcpp_pkg::E_NOT_MQTT;
							else if (role_q == mcpp_pkg::R_CLIENTID && (len > cid_limit
									|| (len == '0 && !cf_q[1])))
								err = mcpp_pkg::E_CLIENTID;
							else if ({12'd0, len} > left) err = mcpp_pkg::E_OVERRUN;
							else begin
								sl_d = len; nmp_d = '0;
								if (len != '0) nxt = PH_SBYTE;
								else begin
									st = after_string(role_q, cf_q, flags_q, type_q);
									nxt = st.ph; role_d = st.role;
								end
							end
						end
						PH_SBYTE: begin
							has = 1'b1; kind = mcpp_pkg::K_STRBYTE; value = {20'd0, data_byte};
							if (role_q == mcpp_pkg::R_PROTONAME && (nmp_q > 3'd3
									|| data_byte != mcpp_pkg::name_char(nmp_q[1:0])))
								err = mcpp_pkg::E_NOT_MQTT;
							nmp_d = nmp_q + 3'd1;
							sl_d = sl_dec;
							if (sl_dec == '0) begin
								st = after_string(role_q, cf_q, flags_q, type_q);
								nxt = st.ph; role_d = st.role;
							end
						end
						PH_LEVEL: begin
							has = 1'b1; kind = mcpp_pkg::K_LEVEL; value = {20'd0, data_byte};
							if (data_byte != level) err = mcpp_pkg::E_LEVEL;
							else nxt = PH_CFLAGS;
						end
						PH_CFLAGS: begin
							has = 1'b1; kind = mcpp_pkg::K_CFLAGS; value = {20'd0, data_byte};
							if (data_byte[0]) err = mcpp_pkg::E_RESERVED;
							else begin cf_d = data_byte; nxt = PH_KA_HI; end
						end
						PH_KA_LO: begin
							has = 1'b1; kind = mcpp_pkg::K_KEEPALIVE; value = {12'd0, len};
							nxt = PH_SLEN_HI; role_d = mcpp_pkg::R_CLIENTID;
						end
						PH_ID_LO: begin
							has = 1'b1; kind = mcpp_pkg::K_ID; value = {12'd0, len};
							if (type_q == mcpp_pkg::T_PUBLISH) nxt = PH_PAYLOAD;
							else if (type_q == mcpp_pkg::T_SUBSCRIBE
									|| type_q == mcpp_pkg::T_UNSUBSCRIBE) begin
								nxt = PH_SLEN_HI; role_d = mcpp_pkg::R_FILTER;
							end else nxt = PH_DONE;
						end
						PH_QOS: begin
							has = 1'b1; kind = mcpp_pkg::K_QOS; value = {20'd0, data_byte};
							if (data_byte > 8'd2) err = mcpp_pkg::E_RESERVED;
							else nxt = PH_FILT_NEXT;
						end
						PH_PAYLOAD: begin
							has = 1'b1; kind = mcpp_pkg::K_PAYLOAD; value = {20'd0, data_byte};
						end
						default: err = mcpp_pkg::E_OVERRUN;
					endcase
				end
			endcase

			if (fin) begin
				bl_d = left;
				terminal = (nxt == PH_PAYLOAD || nxt == PH_DONE || nxt == PH_FILT_NEXT);
				if (err == mcpp_pkg::E_NONE) begin
					if (left == '0 && !terminal) err = mcpp_pkg::E_OVERRUN;
					else if (left != '0 && nxt == PH_DONE) err = mcpp_pkg::E_OVERRUN;
				end
				if (err != mcpp_pkg::E_NONE) begin
					ph_d = (left == '0) ? PH_HDR : PH_SKIP;
					emit_err = 1'b1;
				end else begin
					ph_d = (left == '0) ? PH_HDR : nxt;
					res_valid = has;
					out_kind = kind; out_value = value; out_eop = (left == '0);
				end
			end
			if (emit_err) begin
				res_valid = 1'b1;
				out_kind = mcpp_pkg::K_ERROR; out_value = '0; out_eop = 1'b1;
			end
		end
		res.packet_type = type_d;
		res.header_flags = flags_d;
		res.field_kind = out_kind;
		res.string_role = (out_kind == mcpp_pkg::K_STRLEN || out_kind == mcpp_pkg::K_STRBYTE)
			? role_d : 3'd0;
		res.field_value = out_value;
		res.fault_code = emit_err ? err : mcpp_pkg::E_NONE;
		res.end_of_packet = out_eop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_HDR; bl_q <= '0; lbi_q <= '0; sl_q <= '0; role_q <= '0;
			type_q <= '0; flags_q <= '0; cf_q <= '0; hold_q <= '0; nmp_q <= '0;
		end else begin
			ph_q <= ph_d; bl_q <= bl_d; lbi_q <= lbi_d; sl_q <= sl_d; role_q <= role_d;
			type_q <= type_d; flags_q <= flags_d; cf_q <= cf_d; hold_q <= hold_d;
			nmp_q <= nmp_d;
		end
	end

endmodule

// ===== hw/rtl/mcpp_queue.sv =====
module mcpp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mcpp_pkg::result_t push_data,
	input  logic              pop,
	output logic              full,
	output logic              not_empty,
	output mcpp_pkg::result_t head
);

	mcpp_pkg::result_t mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full = count_q == 2'd2;
	assign not_empty = count_q != 2'd0;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0; rd_ptr_q <= 1'b0; count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule
